/* hw/rtl/segment_polygon_crossing_test_defines.svh */
// ----------------------------------------------------------------------------
// Segment/polygon crossing test: assertion macros
// Shared property templates; clk and rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POLYGON_CROSSING_TEST_DEFINES_SVH
`define SEGMENT_POLYGON_CROSSING_TEST_DEFINES_SVH

// antecedent and consequent in the same cycle
`define SCX_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define SCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/scx_pkg.sv */
// ----------------------------------------------------------------------------
// scx_pkg
// Shared types and constants of the segment/polygon crossing test.
// ----------------------------------------------------------------------------
package scx_pkg;

    localparam int          EPS_WIDTH    = 32;
    localparam logic [31:0] EPS_RESET    = 32'd175922;  // 1e-8 deg^2 in squared LSBs
    localparam int          FIFO_DEPTH   = 4;
    localparam int          EDGE_LATENCY = 4;           // register stages of an edge lane

    // per-item edge work, decided by the front
    typedef struct packed {
        logic open_vld;   // edge prev -> current exists
        logic ring_end;   // closing edge current -> first, ring parity folds
        logic query_end;  // emit the result after this item
    } scx_ctl_t;

    typedef struct packed {
        logic ring_start;
    } scx_fr_status_t;

    typedef struct packed {
        logic acc_vld;
        logic acc_query_end;
        logic advance;
    } scx_bk_status_t;

endpackage

/* hw/rtl/scx_front.sv */
// ----------------------------------------------------------------------------
// scx_front
// Accepts vertex items, tracks ring start / previous / first vertex and
// tags each item with the edges it completes.
// ----------------------------------------------------------------------------
module scx_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          ring_last,
    input  logic                          query_last,
    input  logic                          q_full,
    output logic                          q_push,
    output scx_pkg::scx_ctl_t             q_ctl,
    output logic signed [COORD_WIDTH-1:0] prev_x,
    output logic signed [COORD_WIDTH-1:0] prev_y,
    output logic signed [COORD_WIDTH-1:0] first_x,
    output logic signed [COORD_WIDTH-1:0] first_y,
    output scx_pkg::scx_fr_status_t       status
);
    import scx_pkg::*;

    logic                          ring_start_reg, ring_start_next;
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg, first_x_next, first_y_next;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic                          accept;
    logic                          ring_end;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign ring_end = ring_last || query_last;   // query end also closes the ring

    assign q_ctl.open_vld  = !ring_start_reg;
    assign q_ctl.ring_end  = ring_end;
    assign q_ctl.query_end = query_last;

    assign prev_x  = prev_x_reg;
    assign prev_y  = prev_y_reg;
    // a ring's first vertex closes onto itself (point edge, no effect)
    assign first_x = ring_start_reg ? vertex_x : first_x_reg;
    assign first_y = ring_start_reg ? vertex_y : first_y_reg;

    assign status.ring_start = ring_start_reg;

    always_comb
    begin
        ring_start_next = ring_start_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        if (accept)
        begin
            first_x_next    = first_x;
            first_y_next    = first_y;
            prev_x_next     = vertex_x;
            prev_y_next     = vertex_y;
            ring_start_next = ring_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_start_reg <= 1'b1;
        end
        else
        begin
            ring_start_reg <= ring_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
    end

endmodule

/* hw/rtl/scx_fifo.sv */
// ----------------------------------------------------------------------------
// scx_fifo
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module scx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             nonempty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/scx_edge.sv */
// ----------------------------------------------------------------------------
// scx_edge
// One edge lane: segment/edge intersection and midpoint ray crossing,
// four register stages, exact arithmetic.
// ----------------------------------------------------------------------------
module scx_edge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [scx_pkg::EPS_WIDTH-1:0]    eps,
    input  logic signed [COORD_WIDTH-1:0]    x1,
    input  logic signed [COORD_WIDTH-1:0]    y1,
    input  logic signed [COORD_WIDTH-1:0]    x2,
    input  logic signed [COORD_WIDTH-1:0]    y2,
    input  logic signed [COORD_WIDTH-1:0]    ax,
    input  logic signed [COORD_WIDTH-1:0]    ay,
    input  logic signed [COORD_WIDTH-1:0]    bx,
    input  logic signed [COORD_WIDTH-1:0]    by,
    output logic                             hit,
    output logic                             toggle
);
    import scx_pkg::*;

    localparam int DW1   = COORD_WIDTH + 1;   // coordinate difference
    localparam int OW    = COORD_WIDTH + 2;   // multiplier operand
    localparam int LO_W  = OW / 2;            // operand split for half-size multipliers
    localparam int HI_W  = OW - LO_W;
    localparam int PLW   = OW + LO_W + 1;
    localparam int PHW   = OW + HI_W;
    localparam int PW    = 2 * OW;            // full product
    localparam int DW    = PW + 1;            // product difference
    localparam int NPROD = 8;

    // product slots
    localparam int P_DEN_A = 0;   // dye * dxs
    localparam int P_DEN_B = 1;   // dxe * dys
    localparam int P_NA_A  = 2;   // dxe * oy
    localparam int P_NA_B  = 3;   // dye * ox
    localparam int P_NB_A  = 4;   // dxs * oy
    localparam int P_NB_B  = 5;   // dys * ox
    localparam int P_RAY_L = 6;   // mx * dye
    localparam int P_RAY_R = 7;   // dxe * my

    // stage 1: differences
    logic signed [DW1-1:0] dxs_reg, dys_reg, dxe_reg, dye_reg, ox_reg, oy_reg;
    logic signed [DW1-1:0] dxs_next, dys_next, dxe_next, dye_next, ox_next, oy_next;
    logic signed [OW-1:0]  mx_reg, my_reg, mx_next, my_next, mb_next;
    logic                  mb_neg_reg, mb_neg_next;

    // stage 2: partial products
    logic signed [OW-1:0]  opa [NPROD];
    logic signed [OW-1:0]  opb [NPROD];
    logic signed [PLW-1:0] pp_lo_reg [NPROD];
    logic signed [PLW-1:0] pp_lo_next [NPROD];
    logic signed [PHW-1:0] pp_hi_reg [NPROD];
    logic signed [PHW-1:0] pp_hi_next [NPROD];
    logic                  straddle2_reg, straddle2_next, dye_pos2_reg, dye_pos2_next;

    // stage 3: full products
    logic signed [PW-1:0]  prod_reg [NPROD];
    logic signed [PW-1:0]  prod_next [NPROD];
    logic                  straddle3_reg, dye_pos3_reg;

    // stage 4: numerators, denominator, ray decision
    logic signed [DW-1:0]  den_reg, nden_reg, na_reg, nb_reg;
    logic signed [DW-1:0]  den_next, nden_next, na_next, nb_next;
    logic                  toggle_reg, toggle_next;

    logic signed [DW-1:0]  mag;
    logic                  den_neg, near_par, iu_a, iu_b;

    // stage 1
    always_comb
    begin
        dxs_next = DW1'(x2) - DW1'(x1);
        dys_next = DW1'(y2) - DW1'(y1);
        dxe_next = DW1'(bx) - DW1'(ax);
        dye_next = DW1'(by) - DW1'(ay);
        ox_next  = DW1'(x1) - DW1'(ax);
        oy_next  = DW1'(y1) - DW1'(ay);
        // midpoint in doubled coordinates, relative to the edge ends
        mx_next  = OW'(x1) + OW'(x2) - (OW'(ax) <<< 1);
        my_next  = OW'(y1) + OW'(y2) - (OW'(ay) <<< 1);
        mb_next  = OW'(y1) + OW'(y2) - (OW'(by) <<< 1);
        mb_neg_next = mb_next[OW-1];
    end

    // stage 2: each product as two narrower ones
    always_comb
    begin
        opa[P_DEN_A] = OW'(dye_reg);  opb[P_DEN_A] = OW'(dxs_reg);
        opa[P_DEN_B] = OW'(dxe_reg);  opb[P_DEN_B] = OW'(dys_reg);
        opa[P_NA_A]  = OW'(dxe_reg);  opb[P_NA_A]  = OW'(oy_reg);
        opa[P_NA_B]  = OW'(dye_reg);  opb[P_NA_B]  = OW'(ox_reg);
        opa[P_NB_A]  = OW'(dxs_reg);  opb[P_NB_A]  = OW'(oy_reg);
        opa[P_NB_B]  = OW'(dys_reg);  opb[P_NB_B]  = OW'(ox_reg);
        opa[P_RAY_L] = mx_reg;        opb[P_RAY_L] = OW'(dye_reg);
        opa[P_RAY_R] = OW'(dxe_reg);  opb[P_RAY_R] = my_reg;
        for (int i = 0; i < NPROD; i++)
        begin
            pp_lo_next[i] = PLW'(opa[i]) * PLW'($signed({1'b0, opb[i][LO_W-1:0]}));
            pp_hi_next[i] = PHW'(opa[i]) * PHW'($signed(opb[i][OW-1:LO_W]));
        end
        // midpoint y lies between the edge ends' y, lower end included, upper end excluded
        straddle2_next = my_reg[OW-1] != mb_neg_reg;
        dye_pos2_next  = !dye_reg[DW1-1] && (dye_reg != '0);
    end

    // stage 3
    always_comb
    begin
        for (int i = 0; i < NPROD; i++)
        begin
            prod_next[i] = (PW'(pp_hi_reg[i]) <<< LO_W) + PW'(pp_lo_reg[i]);
        end
    end

    // stage 4
    always_comb
    begin
        den_next  = DW'(prod_reg[P_DEN_A]) - DW'(prod_reg[P_DEN_B]);
        nden_next = DW'(prod_reg[P_DEN_B]) - DW'(prod_reg[P_DEN_A]);
        na_next   = DW'(prod_reg[P_NA_A]) - DW'(prod_reg[P_NA_B]);
        nb_next   = DW'(prod_reg[P_NB_A]) - DW'(prod_reg[P_NB_B]);
        toggle_next = straddle3_reg &&
                      (dye_pos3_reg ? (prod_reg[P_RAY_L] < prod_reg[P_RAY_R])
                                    : (prod_reg[P_RAY_R] < prod_reg[P_RAY_L]));
    end

    // decision: both parameters in [0,1], denominator not near parallel
    always_comb
    begin
        den_neg  = den_reg[DW-1];
        mag      = den_neg ? nden_reg : den_reg;
        near_par = $unsigned(mag) < DW'(eps);
        if (den_neg)
        begin
            iu_a = (na_reg >= den_reg) && (na_reg[DW-1] || (na_reg == '0));
            iu_b = (nb_reg >= den_reg) && (nb_reg[DW-1] || (nb_reg == '0));
        end
        else
        begin
            iu_a = !na_reg[DW-1] && (na_reg <= den_reg);
            iu_b = !nb_reg[DW-1] && (nb_reg <= den_reg);
        end
        hit = (den_reg != '0) && !near_par && iu_a && iu_b;
    end

    assign toggle = toggle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxs_reg       <= dxs_next;
            dys_reg       <= dys_next;
            dxe_reg       <= dxe_next;
            dye_reg       <= dye_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            mb_neg_reg    <= mb_neg_next;
            pp_lo_reg     <= pp_lo_next;
            pp_hi_reg     <= pp_hi_next;
            straddle2_reg <= straddle2_next;
            dye_pos2_reg  <= dye_pos2_next;
            prod_reg      <= prod_next;
            straddle3_reg <= straddle2_reg;
            dye_pos3_reg  <= dye_pos2_reg;
            den_reg       <= den_next;
            nden_reg      <= nden_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            toggle_reg    <= toggle_next;
        end
    end

endmodule

/* hw/rtl/scx_back.sv */
// ----------------------------------------------------------------------------
// scx_back
// The open and closing edge lanes plus the per-ring parity and
// per-query accumulation with the result register.
// ----------------------------------------------------------------------------
module scx_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_vld,
    input  scx_pkg::scx_ctl_t             head_ctl,
    input  logic signed [COORD_WIDTH-1:0] seg_x1,
    input  logic signed [COORD_WIDTH-1:0] seg_y1,
    input  logic signed [COORD_WIDTH-1:0] seg_x2,
    input  logic signed [COORD_WIDTH-1:0] seg_y2,
    input  logic signed [COORD_WIDTH-1:0] cur_x,
    input  logic signed [COORD_WIDTH-1:0] cur_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic [scx_pkg::EPS_WIDTH-1:0] eps,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          crosses,
    output logic                          edge_hit,
    output logic                          midpoint_inside,
    output scx_pkg::scx_bk_status_t       status
);
    import scx_pkg::*;

    logic                    advance;
    logic [EDGE_LATENCY-1:0] vld_reg, vld_next;
    scx_ctl_t                ctl_reg [EDGE_LATENCY];
    scx_ctl_t                acc_ctl;
    logic                    acc_vld;
    logic                    hit_open, tog_open, hit_close, tog_close;
    logic                    par1, par2, eh, ins;
    logic                    parity_reg, parity_next;
    logic                    eh_seen_reg, eh_seen_next;
    logic                    in_seen_reg, in_seen_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    crosses_reg, edge_hit_reg, mid_in_reg;
    logic                    load_out;

    // whole pipe moves unless a finished result is still waiting
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && head_vld;

    scx_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_open (
        .clk    (clk),
        .en     (advance),
        .eps    (eps),
        .x1     (seg_x1),
        .y1     (seg_y1),
        .x2     (seg_x2),
        .y2     (seg_y2),
        .ax     (prev_x),
        .ay     (prev_y),
        .bx     (cur_x),
        .by     (cur_y),
        .hit    (hit_open),
        .toggle (tog_open)
    );

    scx_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
        .clk    (clk),
        .en     (advance),
        .eps    (eps),
        .x1     (seg_x1),
        .y1     (seg_y1),
        .x2     (seg_x2),
        .y2     (seg_y2),
        .ax     (cur_x),
        .ay     (cur_y),
        .bx     (first_x),
        .by     (first_y),
        .hit    (hit_close),
        .toggle (tog_close)
    );

    assign vld_next = {vld_reg[EDGE_LATENCY-2:0], head_vld};
    assign acc_vld  = vld_reg[EDGE_LATENCY-1];
    assign acc_ctl  = ctl_reg[EDGE_LATENCY-1];
    assign load_out = advance && acc_vld && acc_ctl.query_end;

    // open edge toggles first, then the closing edge
    always_comb
    begin
        par1 = parity_reg ^ (acc_ctl.open_vld && tog_open);
        par2 = par1 ^ (acc_ctl.ring_end && tog_close);
        eh   = eh_seen_reg || (acc_ctl.open_vld && hit_open) || (acc_ctl.ring_end && hit_close);
        ins  = in_seen_reg || (acc_ctl.ring_end && par2);

        parity_next    = parity_reg;
        eh_seen_next   = eh_seen_reg;
        in_seen_next   = in_seen_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = acc_vld && acc_ctl.query_end;
            if (acc_vld)
            begin
                parity_next  = acc_ctl.ring_end ? 1'b0 : par2;
                eh_seen_next = acc_ctl.query_end ? 1'b0 : eh;
                in_seen_next = acc_ctl.query_end ? 1'b0 : ins;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            parity_reg    <= 1'b0;
            eh_seen_reg   <= 1'b0;
            in_seen_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                vld_reg <= vld_next;
            end
            parity_reg    <= parity_next;
            eh_seen_reg   <= eh_seen_next;
            in_seen_reg   <= in_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0] <= head_ctl;
            for (int i = 1; i < EDGE_LATENCY; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
        if (load_out)
        begin
            crosses_reg  <= eh || ins;
            edge_hit_reg <= eh;
            mid_in_reg   <= ins;
        end
    end

    assign out_valid       = out_valid_reg;
    assign crosses         = crosses_reg;
    assign edge_hit        = edge_hit_reg;
    assign midpoint_inside = mid_in_reg;

    assign status.acc_vld       = acc_vld;
    assign status.acc_query_end = acc_ctl.query_end;
    assign status.advance       = advance;

endmodule

/* hw/rtl/segment_polygon_crossing_test.sv */
// ----------------------------------------------------------------------------
// segment_polygon_crossing_test
// Tests a query segment against a stream of polygon rings; one result
// per query.
// ----------------------------------------------------------------------------
// Each input item is one ring vertex plus the query segment. The block takes
// one item per clock cycle while the queue has room: the front accepts and tags
// the item with the edges it completes (prev->current, and current->first on a
// ring end), a 4-entry queue decouples it from the back, and the back runs both
// edges in two parallel lanes of four register stages (differences, half-width
// partial products, full products, numerators/denominator) ahead of the
// accumulate stage. The item carrying query_last passes the queue and the lane
// stages; out_valid rises when the accumulate stage registers its flags; in_ready
// only drops when the queue fills while a result waits on out_ready.
// Intersection is inclusive at both ends of both segments; |denominator| below
// parallel_epsilon (or zero) is no hit. The midpoint parity test is exact in
// doubled coordinates. crosses is edge_hit OR midpoint_inside. parallel_epsilon
// resets to 175922 and must only be written while no item is in flight.
// ----------------------------------------------------------------------------
`include "segment_polygon_crossing_test_defines.svh"

module segment_polygon_crossing_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: parallel_epsilon
    input  logic                          cfg_we,
    input  logic [scx_pkg::EPS_WIDTH-1:0] cfg_wdata,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] seg_x1,
    input  logic signed [COORD_WIDTH-1:0] seg_y1,
    input  logic signed [COORD_WIDTH-1:0] seg_x2,
    input  logic signed [COORD_WIDTH-1:0] seg_y2,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          ring_last,
    input  logic                          query_last,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          crosses,
    output logic                          edge_hit,
    output logic                          midpoint_inside
);
    import scx_pkg::*;

    localparam int CTL_W = $bits(scx_ctl_t);
    localparam int QW    = CTL_W + 10 * COORD_WIDTH;

    logic [EPS_WIDTH-1:0]          eps_reg, eps_next;

    // front -> queue
    logic                          q_push, q_full, q_pop, q_nonempty;
    scx_ctl_t                      f_ctl;
    logic signed [COORD_WIDTH-1:0] f_prev_x, f_prev_y, f_first_x, f_first_y;
    logic [QW-1:0]                 q_wdata, q_rdata;
    scx_fr_status_t                fr_status;

    // queue head
    scx_ctl_t                      h_ctl;
    logic signed [COORD_WIDTH-1:0] h_x1, h_y1, h_x2, h_y2;
    logic signed [COORD_WIDTH-1:0] h_cx, h_cy, h_px, h_py, h_fx, h_fy;
    scx_bk_status_t                bk_status;

    // epsilon register
    assign eps_next = cfg_we ? cfg_wdata : eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else
        begin
            eps_reg <= eps_next;
        end
    end

    scx_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .ring_last  (ring_last),
        .query_last (query_last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .prev_x     (f_prev_x),
        .prev_y     (f_prev_y),
        .first_x    (f_first_x),
        .first_y    (f_first_y),
        .status     (fr_status)
    );

    // each queued item carries everything its edges need
    assign q_wdata = {f_ctl, seg_x1, seg_y1, seg_x2, seg_y2, vertex_x, vertex_y,
                      f_prev_x, f_prev_y, f_first_x, f_first_y};

    scx_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .nonempty (q_nonempty)
    );

    assign {h_ctl, h_x1, h_y1, h_x2, h_y2, h_cx, h_cy, h_px, h_py, h_fx, h_fy} = q_rdata;

    scx_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_vld        (q_nonempty),
        .head_ctl        (h_ctl),
        .seg_x1          (h_x1),
        .seg_y1          (h_y1),
        .seg_x2          (h_x2),
        .seg_y2          (h_y2),
        .cur_x           (h_cx),
        .cur_y           (h_cy),
        .prev_x          (h_px),
        .prev_y          (h_py),
        .first_x         (h_fx),
        .first_y         (h_fy),
        .eps             (eps_reg),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .crosses         (crosses),
        .edge_hit        (edge_hit),
        .midpoint_inside (midpoint_inside),
        .status          (bk_status)
    );

    // a query end leaving the accumulate stage always becomes a result
    `SCX_ASSERT_NEXT(a_qend_emits, bk_status.acc_vld && bk_status.acc_query_end && bk_status.advance, out_valid, "query end did not produce a result")
    // a new result only comes from a query end in the accumulate stage
    `SCX_ASSERT_SAME(a_result_source, $rose(out_valid), $past(bk_status.acc_vld && bk_status.acc_query_end), "result without query end")
    // the vertex after a query end opens a fresh ring
    `SCX_ASSERT_NEXT(a_qend_reopens, in_valid && in_ready && query_last, fr_status.ring_start, "ring not reopened after query end")
    // summary flag consistent with its parts
    `SCX_ASSERT_SAME(a_crosses_or, out_valid, crosses == (edge_hit || midpoint_inside), "crosses flag inconsistent")

endmodule

/* verif/scx_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing-test scoreboard
// Bit-exact predictor of the segment/polygon crossing test and the store of
// the flag sets that are due. One entry is queued per query end.
// ----------------------------------------------------------------------------
package scx_tb_pkg;

    import scx_pkg::*;

    typedef logic signed [31:0]  coord_t;
    typedef logic signed [127:0] prod_t;   // wide enough that no product wraps

    typedef struct packed {
        coord_t sx1;
        coord_t sy1;
        coord_t sx2;
        coord_t sy2;
        coord_t vx;
        coord_t vy;
        logic   ring_end;
        logic   query_end;
    } vertex_item_t;

    typedef struct packed {
        logic crosses;
        logic edge_hit;
        logic midpoint_inside;
    } crossing_flags_t;

    class crossing_scoreboard;

        logic [EPS_WIDTH-1:0] epsilon;
        coord_t               first_x, first_y, prev_x, prev_y;
        bit                   opens_ring, parity, hit_seen, inside_seen;
        crossing_flags_t      flags_due[$];
        int unsigned          mismatches, results_seen, hits_seen, insides_seen;

        function new();
            epsilon     = EPS_RESET;
            first_x     = '0;
            first_y     = '0;
            prev_x      = '0;
            prev_y      = '0;
            opens_ring  = 1'b1;
            parity      = 1'b0;
            hit_seen    = 1'b0;
            inside_seen = 1'b0;
        endfunction

        function int pending();
            return flags_due.size();
        endfunction

        // num/den within [0,1], den nonzero
        function bit in_unit(prod_t num, prod_t den);
            if (den < 0)
                return (num >= den) && (num <= 0);
            return (num >= 0) && (num <= den);
        endfunction

        // one ring side a->b against segment (x1,y1)-(x2,y2)
        function void eval_side(prod_t x1, prod_t y1, prod_t x2, prod_t y2,
                                prod_t ax, prod_t ay, prod_t bx, prod_t by);
            prod_t dxs, dys, dxe, dye, ox, oy, den, mag, na, nb;
            prod_t mx2, my2, lhs, rhs, eps_w;
            bit    toggle;
            dxs   = x2 - x1;
            dys   = y2 - y1;
            dxe   = bx - ax;
            dye   = by - ay;
            ox    = x1 - ax;
            oy    = y1 - ay;
            den   = dye * dxs - dxe * dys;
            mag   = (den < 0) ? -den : den;
            eps_w = prod_t'({96'd0, epsilon});
            if (den != 0 && !(mag < eps_w)) begin
                na = dxe * oy - dye * ox;
                nb = dxs * oy - dys * ox;
                if (in_unit(na, den) && in_unit(nb, den))
                    hit_seen = 1'b1;
            end
            // midpoint parity, doubled coordinates keep it exact
            mx2 = x1 + x2;
            my2 = y1 + y2;
            if ((2 * ay > my2) != (2 * by > my2)) begin
                lhs    = (mx2 - 2 * ax) * dye;
                rhs    = dxe * (my2 - 2 * ay);
                toggle = (dye > 0) ? (lhs < rhs) : (rhs < lhs);
                if (toggle)
                    parity = ~parity;
            end
        endfunction

        function void note_vertex(vertex_item_t item);
            bit              closes;
            crossing_flags_t due;
            closes = item.ring_end || item.query_end;
            if (opens_ring) begin
                first_x    = item.vx;
                first_y    = item.vy;
                opens_ring = 1'b0;
            end else begin
                eval_side(item.sx1, item.sy1, item.sx2, item.sy2,
                          prev_x, prev_y, item.vx, item.vy);
            end
            prev_x = item.vx;
            prev_y = item.vy;
            if (closes) begin
                eval_side(item.sx1, item.sy1, item.sx2, item.sy2,
                          item.vx, item.vy, first_x, first_y);
                if (parity)
                    inside_seen = 1'b1;
                parity     = 1'b0;
                opens_ring = 1'b1;
            end
            if (item.query_end) begin
                due.edge_hit        = hit_seen;
                due.midpoint_inside = inside_seen;
                due.crosses         = hit_seen || inside_seen;
                flags_due           = {flags_due, due};
                hit_seen    = 1'b0;
                inside_seen = 1'b0;
            end
        endfunction

        function void flag_field(string name, logic want, logic got);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d %s expected %0b got %0b",
                         results_seen, name, want, got);
        endfunction

        function void check_result(crossing_flags_t got);
            crossing_flags_t want;
            results_seen++;
            if (got.edge_hit === 1'b1)
                hits_seen++;
            if (got.midpoint_inside === 1'b1)
                insides_seen++;
            if (flags_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d arrived with none due (%0b%0b%0b)",
                             results_seen, got.crosses, got.edge_hit,
                             got.midpoint_inside);
                return;
            end
            want = flags_due.pop_front();
            if (got.crosses !== want.crosses)
                flag_field("crosses", want.crosses, got.crosses);
            if (got.edge_hit !== want.edge_hit)
                flag_field("edge_hit", want.edge_hit, got.edge_hit);
            if (got.midpoint_inside !== want.midpoint_inside)
                flag_field("midpoint_inside", want.midpoint_inside, got.midpoint_inside);
        endfunction

    endclass

endpackage

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: segment/polygon crossing test regression
// Streams ring vertices with query segments into the block, predicts the
// per-query flags bit-exactly and compares every result. Runs a directed
// set, then random queries under several parallel thresholds, with random
// gaps on both handshakes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    import scx_pkg::*;
    import scx_tb_pkg::*;

    localparam int UNIT            = 1 << 22;          // one degree in Q9.22
    localparam int CMIN            = 32'sh8000_0000;
    localparam int CMAX            = 32'sh7fff_ffff;
    localparam int DRAIN_CYCLES    = 4 * (EDGE_LATENCY + FIFO_DEPTH);
    localparam int ITEMS_PER_PHASE = 190;
    localparam int LIMIT_NS        = 1_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [EPS_WIDTH-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    vertex_item_t         tx_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 crosses;
    logic                 edge_hit;
    logic                 midpoint_inside;

    crossing_scoreboard   sb;
    crossing_flags_t      got_flags;

    // pacing knobs of the driver (tx_eager) and the receiver (rx_eager, rx_hold_len)
    bit                   tx_eager    = 1'b0;
    bit                   rx_eager    = 1'b0;
    int unsigned          rx_hold_len = 0;

    int unsigned          items_sent      = 0;
    int unsigned          in_stall_cycles = 0;
    int unsigned          eps_writes      = 0;
    logic [EPS_WIDTH-1:0] eps_plan [5];

    segment_polygon_crossing_test u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .seg_x1          (tx_item.sx1),
        .seg_y1          (tx_item.sy1),
        .seg_x2          (tx_item.sx2),
        .seg_y2          (tx_item.sy2),
        .vertex_x        (tx_item.vx),
        .vertex_y        (tx_item.vy),
        .ring_last       (tx_item.ring_end),
        .query_last      (tx_item.query_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .crosses         (crosses),
        .edge_hit        (edge_hit),
        .midpoint_inside (midpoint_inside)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: inputs only move on the falling edge, so everything seen here
    // is the pre-edge value the block also sees.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_vertex(tx_item);
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (out_valid && out_ready)
            begin
                got_flags.crosses         = crosses;
                got_flags.edge_hit        = edge_hit;
                got_flags.midpoint_inside = midpoint_inside;
                sb.check_result(got_flags);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per result; a requested hold-off keeps ready low
    // for a long stretch so a held result backs up the queue into in_ready.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len != 0)
            begin
                out_ready = 1'b0;
                repeat (rx_hold_len) @(negedge clk);
                rx_hold_len = 0;
            end
            stall = rx_eager ? 0 : $urandom_range(0, 12);
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One item: optional idle gap, then hold valid until taken. A zero gap
    // keeps valid high and only swaps the payload.
    task automatic send_vertex(input vertex_item_t item);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tx_item  = item;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_point(input int x1, input int y1, input int x2, input int y2,
                              input int vx, input int vy, input bit rl, input bit ql);
        vertex_item_t item;
        item.sx1       = x1;
        item.sy1       = y1;
        item.sx2       = x2;
        item.sy2       = y2;
        item.vx        = vx;
        item.vy        = vy;
        item.ring_end  = rl;
        item.query_end = ql;
        send_vertex(item);
    endtask

    // Wait until every due result is back, then let trailing vertices that
    // make no result clear the edge lanes before touching the register.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        sb.epsilon = value;
        eps_writes++;
    endtask

    function automatic int near(input int c, input int r);
        return c + int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // full-range coordinate with the extremes weighted in
    function automatic int wild();
        case ($urandom_range(0, 5))
            0:       return CMIN;
            1:       return CMAX;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random query. Mostly well-formed: 1..3 rings around a common center
    // with the segment nearby, so hits, touches and inside cases are common
    // at every scale. A few queries use full-range coordinates; a few are
    // pure noise with random flags that may leave the query open.
    // ------------------------------------------------------------------------
    task automatic send_random_query();
        vertex_item_t items[$];
        vertex_item_t item;
        int           cx, cy, r, rings, count, seg_kind, idx, sz;
        bit           is_wild, box, flip, vary_seg, last;
        int unsigned  pick;
        item = '0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++)
            begin
                item.sx1       = $urandom;
                item.sy1       = $urandom;
                item.sx2       = $urandom;
                item.sy2       = $urandom;
                item.vx        = $urandom;
                item.vy        = $urandom;
                item.ring_end  = $urandom_range(0, 1);
                item.query_end = (i == count - 1) ? ($urandom_range(0, 3) != 0)
                                                  : ($urandom_range(0, 9) == 0);
                items = {items, item};
            end
        end
        else
        begin
            is_wild  = (pick <= 3);
            cx       = int'($urandom) >>> 2;
            cy       = int'($urandom) >>> 2;
            r        = 1 << $urandom_range(2, 24);
            vary_seg = ($urandom_range(0, 9) == 0);
            seg_kind = $urandom_range(0, 3);     // 2: short segment, 3: a point
            rings    = $urandom_range(1, 3);
            for (int k = 0; k < rings; k++)
            begin
                box  = ($urandom_range(0, 2) == 0);
                flip = $urandom_range(0, 1);
                sz   = $urandom_range(0, 19);
                if (box)
                    count = 4;
                else if (sz == 0)
                    count = 1;
                else if (sz == 1)
                    count = 2;
                else if (sz == 2)
                    count = $urandom_range(8, 12);
                else
                    count = $urandom_range(3, 6);
                for (int j = 0; j < count; j++)
                begin
                    // segment is normally fixed for the query; some queries
                    // change it mid-ring
                    if ((k == 0 && j == 0) || (vary_seg && $urandom_range(0, 1)))
                    begin
                        if (is_wild)
                        begin
                            item.sx1 = wild();
                            item.sy1 = wild();
                            item.sx2 = wild();
                            item.sy2 = wild();
                        end
                        else if (seg_kind == 2)
                        begin
                            item.sx1 = near(cx, r / 4);
                            item.sy1 = near(cy, r / 4);
                            item.sx2 = near(cx, r / 4);
                            item.sy2 = near(cy, r / 4);
                        end
                        else
                        begin
                            item.sx1 = near(cx, 2 * r);
                            item.sy1 = near(cy, 2 * r);
                            item.sx2 = near(cx, 2 * r);
                            item.sy2 = near(cy, 2 * r);
                        end
                        if (seg_kind == 3)
                        begin
                            item.sx2 = item.sx1;
                            item.sy2 = item.sy1;
                        end
                    end
                    // occasionally repeat the previous vertex: zero-length side
                    if (!(j > 0 && $urandom_range(0, 19) == 0))
                    begin
                        if (is_wild)
                        begin
                            item.vx = wild();
                            item.vy = wild();
                        end
                        else if (box)
                        begin
                            idx     = flip ? 3 - j : j;
                            item.vx = near((idx == 1 || idx == 2) ? cx + r : cx - r, r / 4);
                            item.vy = near((idx >= 2) ? cy + r : cy - r, r / 4);
                        end
                        else
                        begin
                            item.vx = near(cx, r);
                            item.vy = near(cy, r);
                        end
                    end
                    last           = (j == count - 1);
                    item.query_end = last && (k == rings - 1);
                    item.ring_end  = last && (k < rings - 1 || $urandom_range(0, 3) != 0);
                    items = {items, item};
                end
            end
        end
        foreach (items[i])
            send_vertex(items[i]);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            // flip into and out of back-to-back stretches now and then
            if ($urandom_range(0, 7) == 0)
                tx_eager = ~tx_eager;
            if ($urandom_range(0, 7) == 0)
                rx_eager = ~rx_eager;
            send_random_query();
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed set: crossing plus inside, inside only with the query closing
    // an open ring, a one-vertex ring on the segment, collinear sides (zero
    // denominator), an endpoint touching a side, extreme coordinates, the
    // segment changing between items across two rings, and -1/0 corners.
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // segment through the square |x|,|y| <= UNIT, midpoint at the center
        send_point(-2 * UNIT, 0, 2 * UNIT, 0, -UNIT, -UNIT, 1'b0, 1'b0);
        send_point(-2 * UNIT, 0, 2 * UNIT, 0,  UNIT, -UNIT, 1'b0, 1'b0);
        send_point(-2 * UNIT, 0, 2 * UNIT, 0,  UNIT,  UNIT, 1'b0, 1'b0);
        send_point(-2 * UNIT, 0, 2 * UNIT, 0, -UNIT,  UNIT, 1'b1, 1'b1);
        // short segment wholly inside; query end closes the ring
        send_point(-UNIT / 4, 0, UNIT / 4, UNIT / 8, -UNIT, -UNIT, 1'b0, 1'b0);
        send_point(-UNIT / 4, 0, UNIT / 4, UNIT / 8,  UNIT, -UNIT, 1'b0, 1'b0);
        send_point(-UNIT / 4, 0, UNIT / 4, UNIT / 8,  UNIT,  UNIT, 1'b0, 1'b0);
        send_point(-UNIT / 4, 0, UNIT / 4, UNIT / 8, -UNIT,  UNIT, 1'b0, 1'b1);
        // one-vertex ring lying on the segment: a point, never a hit
        send_point(0, 0, UNIT, 0, UNIT / 2, 0, 1'b1, 1'b1);
        // two-vertex ring collinear with the segment
        send_point(-2 * UNIT, -UNIT, 2 * UNIT, -UNIT, -UNIT, -UNIT, 1'b0, 1'b0);
        send_point(-2 * UNIT, -UNIT, 2 * UNIT, -UNIT,  UNIT, -UNIT, 1'b1, 1'b1);
        // segment end exactly on a side (inclusive)
        send_point(0, 0, UNIT, 0, UNIT, -UNIT, 1'b0, 1'b0);
        send_point(0, 0, UNIT, 0, UNIT,  UNIT, 1'b1, 1'b1);
        // full-scale diagonals
        send_point(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, 1'b0, 1'b0);
        send_point(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, 1'b0, 1'b0);
        send_point(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 1'b1, 1'b1);
        // far ring, then a ring whose sides each see a different segment
        send_point(0, 0, UNIT, UNIT, 10 * UNIT, 10 * UNIT, 1'b0, 1'b0);
        send_point(0, 0, UNIT, UNIT, 11 * UNIT, 10 * UNIT, 1'b0, 1'b0);
        send_point(0, 0, UNIT, UNIT, 11 * UNIT, 11 * UNIT, 1'b1, 1'b0);
        send_point(-3 * UNIT, 0, -2 * UNIT, 0, -UNIT, -UNIT, 1'b0, 1'b0);
        send_point(0, -3 * UNIT, 0, 3 * UNIT,  UNIT, -UNIT, 1'b0, 1'b0);
        send_point(2 * UNIT, 2 * UNIT, 3 * UNIT, 3 * UNIT, UNIT, UNIT, 1'b0, 1'b0);
        send_point(-UNIT / 2, 0, UNIT / 2, 0, -UNIT, UNIT, 1'b1, 1'b1);
        // LSB-sized ring around the origin
        send_point(-1, -1, 0, 0, 0, -1, 1'b0, 1'b0);
        send_point(-1, -1, 0, 0, -1, 0, 1'b1, 1'b1);
    endtask

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main
        sb          = new();
        eps_plan[0] = '0;
        eps_plan[1] = '1;
        eps_plan[2] = 32'd1;
        eps_plan[3] = $urandom;
        eps_plan[4] = EPS_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset threshold in force for the first phase
        run_directed();
        run_random(ITEMS_PER_PHASE);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_epsilon(eps_plan[p]);
            if (p == 0)
            begin
                // back-pressure burst: sender flat out, receiver parked
                tx_eager    = 1'b1;
                rx_hold_len = 64;
                repeat (10) send_random_query();
                tx_eager    = 1'b0;
            end
            run_random(ITEMS_PER_PHASE);
        end

        settle();
        $display("Covered %0d vertex items and %0d queries (%0d edge hits, %0d midpoint inside)",
                 items_sent, sb.results_seen, sb.hits_seen, sb.insides_seen);
        $display("over %0d threshold writes incl. 0 and all-ones; in_ready low %0d cycles, %0d errors",
                 eps_writes, in_stall_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* segment_polygon_crossing_test.f */
+incdir+hw/rtl
hw/rtl/scx_pkg.sv
hw/rtl/scx_front.sv
hw/rtl/scx_fifo.sv
hw/rtl/scx_edge.sv
hw/rtl/scx_back.sv
hw/rtl/segment_polygon_crossing_test.sv
verif/scx_tb_pkg.sv
verif/tb.sv
